// ===== sv/mpps_pkg.sv =====
// ----------------------------------------------------------------------------
// mpps_pkg
// Shared widths, codes and types of the mirror point pair search block.
// ----------------------------------------------------------------------------
package mpps_pkg;

   localparam int MAX_POINTS = 64;              // cells in the compare chain
   localparam int IDX_W      = 6;               // point index width
   localparam int CNT_W      = 7;               // point count width
   localparam int COORD_W    = 32;
   localparam int TOL_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AXIS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EPS  = 2'd2;

   // pair status codes
   localparam logic [1:0] ST_PAIRED       = 2'd0;
   localparam logic [1:0] ST_NOT_MIRRORED = 2'd1;
   localparam logic [1:0] ST_NOTHING      = 2'd2;

   typedef enum logic [2:0] {
      PH_LOAD  = 3'b001,
      PH_SCAN  = 3'b010,
      PH_DRAIN = 3'b100
   } phase_type;

   // query token walking down the chain
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic                      off;
      logic                      found;
      logic [IDX_W-1:0]          idx;
      logic [IDX_W-1:0]          pos;
      logic [IDX_W-1:0]          partner;
      logic signed [COORD_W-1:0] ca;
      logic signed [COORD_W-1:0] co;
   } tok_type;

   typedef struct packed {
      logic [IDX_W-1:0] orig_index;
      logic [IDX_W-1:0] partner_index;
      logic [1:0]       pair_status;
      logic             run_end;
      logic             count_error;
   } res_type;

endpackage

// ===== sv/mpps_ifs.sv =====
// ----------------------------------------------------------------------------
// mpps channel interfaces
// Point input, result output and register write channels.
// ----------------------------------------------------------------------------
interface mpps_req_if import mpps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;
   logic                      last_point;

   modport source (output valid, output x_coord, output y_coord, output last_point,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input last_point,
                   output ready);
endinterface

interface mpps_rsp_if import mpps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] orig_index;
   logic [IDX_W-1:0] partner_index;
   logic [1:0]       pair_status;
   logic             run_end;
   logic             count_error;

   modport source (output valid, output orig_index, output partner_index,
                   output pair_status, output run_end, output count_error,
                   input ready);
   modport sink   (input valid, input orig_index, input partner_index,
                   input pair_status, input run_end, input count_error,
                   output ready);
endinterface

interface mpps_csr_if import mpps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/mpps_cell.sv =====
// ----------------------------------------------------------------------------
// mpps_cell
// One chain cell: holds a stored point, checks the passing query against it
// and hands the query on to the next cell.
// ----------------------------------------------------------------------------
module mpps_cell import mpps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      clear,
   input  logic                      load_en,
   input  logic signed [COORD_W-1:0] ld_x,
   input  logic signed [COORD_W-1:0] ld_y,
   input  logic                      axis,
   input  logic [TOL_W-1:0]          tol,
   input  tok_type                   q_in,
   output tok_type                   q_out
);

   logic signed [COORD_W-1:0] px_ff;
   logic signed [COORD_W-1:0] py_ff;
   logic                      hold_ff;
   tok_type                   q_ff;
   tok_type                   q_in_nx;

   logic signed [COORD_W-1:0] own_ca;
   logic signed [COORD_W-1:0] own_co;
   logic signed [COORD_W+1:0] sum;
   logic signed [COORD_W+1:0] dif;
   logic signed [COORD_W+1:0] tol_p;
   logic signed [COORD_W+1:0] tol_n;
   logic                      hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else if (clear) begin
         hold_ff <= 1'b0;
      end else if (load_en) begin
         hold_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         px_ff <= ld_x;
         py_ff <= ld_y;
      end
   end

   always_comb begin
      own_ca = axis ? py_ff : px_ff;
      own_co = axis ? px_ff : py_ff;
      sum    = {{2{q_in.ca[COORD_W-1]}}, q_in.ca} + {{2{own_ca[COORD_W-1]}}, own_ca};
      dif    = {{2{q_in.co[COORD_W-1]}}, q_in.co} - {{2{own_co[COORD_W-1]}}, own_co};
      tol_p  = $signed({3'b000, tol});
      tol_n  = -tol_p;
      // |a| < tol written as an open interval
      hit    = hold_ff && (sum < tol_p) && (sum > tol_n) && (dif < tol_p) && (dif > tol_n);

      q_in_nx     = q_in;
      q_in_nx.pos = q_in.pos + IDX_W'(1);
      if (q_in.valid && !q_in.found && hit) begin
         q_in_nx.found   = 1'b1;
         q_in_nx.partner = q_in.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else if (adv) begin
         q_ff <= q_in_nx;
      end
   end

   assign q_out = q_ff;

endmodule

// ===== sv/mirror_point_pair_search_top.sv =====
// ----------------------------------------------------------------------------
// mirror_point_pair_search_top
// Stores a set of 2-D points and reports, for every point off the chosen
// axis, the first stored point that mirrors it, plus a count check.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one point per transaction (x_coord, y_coord, last_point).
//   Points are taken one per cycle while loading; points past the store size
//   are dropped. The transaction with last_point set starts the search and
//   req_chan.ready stays low until the run's final result is presented on
//   rsp_chan.
//   Each stored point is read from the point memory, one per cycle while the
//   chain advances, and sent as a query down a chain of MAX_POINTS compare
//   cells; each cell compares it with its own point and the first hit is kept.
//   A query passes the head stage and every cell before it is retired at the
//   tail; the final result of a run is presented once its last query is
//   retired and the receiver can take it. rsp_chan gives one transaction per
//   off-axis point in index order, the last one with run_end and count_error;
//   a run with no off-axis point gives one "nothing to map" transaction. A
//   stalled receiver freezes the chain when an off-axis query is at its tail.
//   csr_chan writes reflect_axis, match_tolerance, count_epsilon; it is always
//   ready and is to be used only while the block is idle.
//   Reset: axis x, tolerance and epsilon 1, empty point set.
// ----------------------------------------------------------------------------
module mirror_point_pair_search_top import mpps_pkg::*; (
   input logic        clock,
   input logic        reset,
   mpps_req_if.sink   req_chan,
   mpps_rsp_if.source rsp_chan,
   mpps_csr_if.sink   csr_chan
);

   // configuration
   logic             axis_ff;
   logic [TOL_W-1:0] tol_ff;
   logic [TOL_W-1:0] eps_ff;

   phase_type        state_ff;
   logic [CNT_W-1:0] point_cnt_ff;
   logic [CNT_W-1:0] pos_cnt_ff;
   logic [CNT_W-1:0] pairs_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
   logic signed [COORD_W-1:0] mem_y [MAX_POINTS];

   // head stage: query read from memory
   logic                      hv_ff;
   logic                      hlast_ff;
   logic [IDX_W-1:0]          hidx_ff;
   logic signed [COORD_W-1:0] hx_ff;
   logic signed [COORD_W-1:0] hy_ff;

   logic                      pend_v_ff;
   logic                      fin_ff;
   res_type                   pend_ff;
   logic                      rsp_v_ff;
   res_type                   rsp_ff;

   tok_type                   chain [MAX_POINTS+1];
   tok_type                   tail;

   logic                      req_fire;
   logic                      store_ok;
   logic                      ld_fire;
   logic [IDX_W-1:0]          wr_idx;
   logic                      rd_last;
   logic                      adv;
   logic                      can_push;
   logic                      needs_push;
   logic                      consume;
   logic                      run_done;
   logic                      head_pos;
   logic signed [COORD_W:0]   head_ca;
   logic [CNT_W-1:0]          pairs_nx;
   logic [CNT_W:0]            two_pos;
   logic                      err;
   res_type                   tok_res;
   res_type                   pend_nx;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= 1'b0;
         tol_ff  <= TOL_W'(1);
         eps_ff  <= TOL_W'(1);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_AXIS: axis_ff <= csr_chan.data[0];
            REG_TOL:  tol_ff  <= csr_chan.data[TOL_W-1:0];
            REG_EPS:  eps_ff  <= csr_chan.data[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // loading
   assign req_chan.ready = (state_ff == PH_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign store_ok       = (point_cnt_ff < CNT_W'(MAX_POINTS));
   assign ld_fire        = req_fire && store_ok;
   assign wr_idx         = point_cnt_ff[IDX_W-1:0];
   assign rd_last        = ({1'b0, rd_idx_ff} == (point_cnt_ff - CNT_W'(1)));

   always_ff @(posedge clock) begin
      if (ld_fire) begin
         mem_x[wr_idx] <= req_chan.x_coord;
         mem_y[wr_idx] <= req_chan.y_coord;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_LOAD;
         point_cnt_ff <= '0;
         rd_idx_ff    <= '0;
      end else begin
         unique case (state_ff)
            PH_LOAD: begin
               if (ld_fire) begin
                  point_cnt_ff <= point_cnt_ff + CNT_W'(1);
               end
               if (req_fire && req_chan.last_point) begin
                  state_ff  <= PH_SCAN;
                  rd_idx_ff <= '0;
               end
            end
            PH_SCAN: begin
               if (adv) begin
                  if (rd_last) begin
                     state_ff  <= PH_DRAIN;
                     rd_idx_ff <= '0;
                  end else begin
                     rd_idx_ff <= rd_idx_ff + IDX_W'(1);
                  end
               end
            end
            PH_DRAIN: begin
               if (run_done) begin
                  state_ff     <= PH_LOAD;
                  point_cnt_ff <= '0;
               end
            end
            default: state_ff <= PH_LOAD;
         endcase
      end
   end

   // head stage
   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
      end else if (adv) begin
         hv_ff <= (state_ff == PH_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && (state_ff == PH_SCAN)) begin
         hx_ff    <= mem_x[rd_idx_ff];
         hy_ff    <= mem_y[rd_idx_ff];
         hidx_ff  <= rd_idx_ff;
         hlast_ff <= rd_last;
      end
   end

   always_comb begin
      chain[0]         = '0;
      chain[0].valid   = hv_ff;
      chain[0].last    = hlast_ff;
      chain[0].idx     = hidx_ff;
      chain[0].ca      = axis_ff ? hy_ff : hx_ff;
      chain[0].co      = axis_ff ? hx_ff : hy_ff;
      head_ca          = {chain[0].ca[COORD_W-1], chain[0].ca};
      chain[0].off     = (head_ca > $signed({2'b00, tol_ff}))
                      || (head_ca < -$signed({2'b00, tol_ff}));
      head_pos         = (head_ca > $signed({2'b00, eps_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_cnt_ff <= '0;
      end else if (run_done) begin
         pos_cnt_ff <= '0;
      end else if (adv && hv_ff && head_pos) begin
         pos_cnt_ff <= pos_cnt_ff + CNT_W'(1);
      end
   end

   // compare chain
   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
      mpps_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .clear   (run_done),
         .load_en (ld_fire && (wr_idx == IDX_W'(g))),
         .ld_x    (req_chan.x_coord),
         .ld_y    (req_chan.y_coord),
         .axis    (axis_ff),
         .tol     (tol_ff),
         .q_in    (chain[g]),
         .q_out   (chain[g+1])
      );
   end

   assign tail = chain[MAX_POINTS];

   // result ordering: one result is held back so the final one can be marked
   assign can_push   = !rsp_v_ff || rsp_chan.ready;
   assign needs_push = tail.valid && tail.off && pend_v_ff;
   assign consume    = tail.valid && (!needs_push || can_push);
   assign adv        = !tail.valid || consume;
   assign run_done   = fin_ff && can_push;

   always_comb begin
      pairs_nx = pairs_ff + CNT_W'(consume && tail.off && tail.found);
      two_pos  = {pos_cnt_ff, 1'b0};
      err      = ({1'b0, pairs_nx} != two_pos) || (two_pos > {1'b0, point_cnt_ff});

      tok_res.orig_index    = tail.idx;
      tok_res.partner_index = tail.partner;
      tok_res.pair_status   = tail.found ? ST_PAIRED : ST_NOT_MIRRORED;
      tok_res.run_end       = 1'b0;
      tok_res.count_error   = 1'b0;

      if (tail.off) begin
         pend_nx = tok_res;
      end else if (pend_v_ff) begin
         pend_nx = pend_ff;
      end else begin
         pend_nx               = '0;
         pend_nx.pair_status   = ST_NOTHING;
      end
      if (tail.last) begin
         pend_nx.run_end     = 1'b1;
         pend_nx.count_error = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         fin_ff    <= 1'b0;
         pairs_ff  <= '0;
      end else if (run_done) begin
         pend_v_ff <= 1'b0;
         fin_ff    <= 1'b0;
         pairs_ff  <= '0;
      end else if (consume) begin
         pairs_ff <= pairs_nx;
         if (tail.off || tail.last) begin
            pend_v_ff <= 1'b1;
         end
         if (tail.last) begin
            fin_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (consume && (tail.off || tail.last)) begin
         pend_ff <= pend_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if ((needs_push && consume) || run_done) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((needs_push && consume) || run_done) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_chan.valid         = rsp_v_ff;
   assign rsp_chan.orig_index    = rsp_ff.orig_index;
   assign rsp_chan.partner_index = rsp_ff.partner_index;
   assign rsp_chan.pair_status   = rsp_ff.pair_status;
   assign rsp_chan.run_end       = rsp_ff.run_end;
   assign rsp_chan.count_error   = rsp_ff.count_error;

   // no query may still be in flight once the final result is formed
   a_fin_drained: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !tail.valid)
      else $error("query left in chain after final result");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_LOAD) |-> (!hv_ff && !pend_v_ff && !fin_ff))
      else $error("search state left over while loading");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      point_cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store size");

   a_push_shown: assert property (@(posedge clock) disable iff (reset)
      (needs_push && consume) |=> rsp_v_ff)
      else $error("held result lost on push");

endmodule

// ===== verif/mirror_point_pair_search_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_point_pair_search_top_tb
// Loads point sets into the block and checks every pair report against a
// behavioral search model kept in the bench or a short hand-checked table,
// which comes first. Random sets follow under several register settings,
// mostly built from mirrored pairs, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module mirror_point_pair_search_top_tb;
   import mpps_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int NUM_STEER    = 16;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_POINTS = 56;
   localparam int SET_MAX      = MAX_POINTS + 4;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      lst;
      logic [1:0]                n_typed;
      res_type                   t0;
      res_type                   t1;
   } steer_row_type;

   localparam res_type NO_RES = '0;

   // axis x, tolerance 1, epsilon 1 (state after reset)
   steer_row_type steer_table [NUM_STEER] = '{
      '{32'sh0000_0000, 32'sh0000_0000, 1'b1, 2'd1,
        '{6'd0, 6'd0, ST_NOTHING, 1'b1, 1'b0}, NO_RES},
      '{32'sh7FFF_FFFF, 32'sh0000_0000, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'sh8000_0000, 32'sh0000_0000, 1'b1, 2'd2,
        '{6'd0, 6'd0, ST_NOT_MIRRORED, 1'b0, 1'b0},
        '{6'd1, 6'd0, ST_NOT_MIRRORED, 1'b1, 1'b1}},
      '{32'sh0001_0000, 32'sh0000_0005, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'shFFFF_0000, 32'sh0000_0005, 1'b1, 2'd2,
        '{6'd0, 6'd1, ST_PAIRED, 1'b0, 1'b0},
        '{6'd1, 6'd0, ST_PAIRED, 1'b1, 1'b0}},
      // on the tolerance boundary: not off-axis
      '{32'sh0000_0001, 32'sh0000_0000, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'shFFFF_FFFF, 32'sh0000_0000, 1'b1, 2'd1,
        '{6'd0, 6'd0, ST_NOTHING, 1'b1, 1'b0}, NO_RES},
      '{32'sh0000_0002, 32'sh7FFF_FFFF, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'shFFFF_FFFE, 32'sh8000_0000, 1'b1, 2'd2,
        '{6'd0, 6'd0, ST_NOT_MIRRORED, 1'b0, 1'b0},
        '{6'd1, 6'd0, ST_NOT_MIRRORED, 1'b1, 1'b1}},
      // most negative pair: the sum must not wrap
      '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 2'd2,
        '{6'd0, 6'd0, ST_NOT_MIRRORED, 1'b0, 1'b0},
        '{6'd1, 6'd0, ST_NOT_MIRRORED, 1'b1, 1'b0}},
      '{32'sh0000_0003, 32'shFFFF_FFF9, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'shFFFF_FFFD, 32'shFFFF_FFF9, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'sh0000_0000, 32'shFFFF_FFF9, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'sh0001_2345, 32'shFFFF_0000, 1'b0, 2'd0, NO_RES, NO_RES},
      '{32'shFFFE_DCBB, 32'shFFFF_0000, 1'b1, 2'd0, NO_RES, NO_RES}
   };

   logic clock;
   logic reset;

   mpps_req_if req_chan ();
   mpps_rsp_if rsp_chan ();
   mpps_csr_if csr_chan ();

   mirror_point_pair_search_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // bench copy of the block state
   logic                      cfg_axis;
   logic [TOL_W-1:0]          cfg_tol;
   logic [TOL_W-1:0]          cfg_eps;
   logic signed [COORD_W-1:0] pt_x [MAX_POINTS];
   logic signed [COORD_W-1:0] pt_y [MAX_POINTS];
   int                        pt_count;

   res_type search_results [$];
   res_type pair_reports_due [$];
   res_type due;

   bit idle_en;
   int hold_left;
   int cycle_count = 0;
   int n_fail = 0;
   int n_checked = 0;
   int n_points;
   int n_sets;
   int n_settings;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Store one point; on the last point run the search and leave the reports
   // of the run in search_results.
   task automatic store_and_search(input logic signed [COORD_W-1:0] px,
                                   input logic signed [COORD_W-1:0] py,
                                   input logic lst);
      longint  tol, eps, ca_i, co_i, ca_j, co_j, sum, dif;
      int      n, above, hits, partner;
      bit      found, err;
      res_type r;
      search_results.delete();
      if (pt_count < MAX_POINTS) begin
         pt_x[pt_count] = px;
         pt_y[pt_count] = py;
         pt_count++;
      end
      if (!lst) return;
      n   = pt_count;
      tol = longint'({1'b0, cfg_tol});
      eps = longint'({1'b0, cfg_eps});
      above = 0;
      for (int i = 0; i < n; i++) begin
         ca_i = cfg_axis ? pt_y[i] : pt_x[i];
         if (ca_i > eps) above++;
      end
      hits = 0;
      for (int i = 0; i < n; i++) begin
         ca_i = cfg_axis ? pt_y[i] : pt_x[i];
         co_i = cfg_axis ? pt_x[i] : pt_y[i];
         if (!(ca_i > tol || ca_i < -tol)) continue;
         found   = 1'b0;
         partner = 0;
         for (int j = 0; j < n && !found; j++) begin
            ca_j = cfg_axis ? pt_y[j] : pt_x[j];
            co_j = cfg_axis ? pt_x[j] : pt_y[j];
            sum  = ca_i + ca_j;
            dif  = co_i - co_j;
            if ((sum < 0 ? -sum : sum) < tol && (dif < 0 ? -dif : dif) < tol) begin
               found   = 1'b1;
               partner = j;
            end
         end
         if (found) hits++;
         r.orig_index    = IDX_W'(i);
         r.partner_index = IDX_W'(partner);
         r.pair_status   = found ? ST_PAIRED : ST_NOT_MIRRORED;
         r.run_end       = 1'b0;
         r.count_error   = 1'b0;
         search_results.push_back(r);
      end
      err = (hits != 2 * above) || (2 * above > n);
      if (search_results.size() == 0) begin
         r = '{orig_index: '0, partner_index: '0, pair_status: ST_NOTHING,
               run_end: 1'b1, count_error: err};
      end else begin
         r = search_results.pop_back();
         r.run_end     = 1'b1;
         r.count_error = err;
      end
      search_results.push_back(r);
      pt_count = 0;
   endtask

   task automatic push_point(input logic signed [COORD_W-1:0] px,
                             input logic signed [COORD_W-1:0] py,
                             input logic lst, input bit predict);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.x_coord    <= px;
      req_chan.y_coord    <= py;
      req_chan.last_point <= lst;
      do @(posedge clock); while (!req_chan.ready);
      store_and_search(px, py, lst);
      if (predict)
         foreach (search_results[k]) pair_reports_due.push_back(search_results[k]);
      n_points++;
      if (lst) n_sets++;
   endtask

   // Drop valid, drain every report, then give the chain time to empty.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pair_reports_due.size() != 0) @(posedge clock);
      repeat (MAX_POINTS + 8) @(posedge clock);
   endtask

   task automatic write_settings(input logic axis, input logic [TOL_W-1:0] tol,
                                 input logic [TOL_W-1:0] eps);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_IDX_W-1:0]  reg_idx;
      for (int r = 0; r < 3; r++) begin
         case (r)
            0: begin
               reg_idx = REG_AXIS;
               value   = {31'd0, axis};
            end
            1: begin
               reg_idx = REG_TOL;
               value   = {1'b0, tol};
            end
            default: begin
               reg_idx = REG_EPS;
               value   = {1'b0, eps};
            end
         endcase
         csr_chan.valid <= 1'b1;
         csr_chan.index <= reg_idx;
         csr_chan.data  <= value;
         do @(posedge clock); while (!csr_chan.ready);
         case (reg_idx)
            REG_AXIS: cfg_axis = value[0];
            REG_TOL:  cfg_tol  = value[TOL_W-1:0];
            REG_EPS:  cfg_eps  = value[TOL_W-1:0];
            default: ;
         endcase
      end
      csr_chan.valid <= 1'b0;
      n_settings++;
   endtask

   // offset that usually keeps a mirror inside the tolerance, now and then
   // lands exactly on it
   function automatic logic signed [COORD_W-1:0] jitter();
      int unsigned               m;
      logic signed [COORD_W-1:0] v;
      m = (cfg_tol > 31'h0001_0000) ? 32'h0001_0000 : 32'(cfg_tol);
      v = $urandom_range(0, m);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic logic signed [COORD_W-1:0] pick_coord();
      int unsigned               span;
      logic signed [COORD_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            span = (cfg_tol > 31'h0004_0000) ? 32'h0010_0000 : 32'(cfg_tol) * 4 + 4;
            v    = $urandom_range(0, 2 * span) - span;
         end
         2: begin
            v = {1'b0, cfg_tol} + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 32'sh0000_0000;
               default: v = {1'b0, cfg_eps} + $urandom_range(0, 2) - 1;
            endcase
         end
      endcase
      return v;
   endfunction

   // One point set: mostly mirrored pairs with small offsets, some pure noise,
   // now and then a full store or an overflowing one.
   task automatic send_point_set();
      logic signed [COORD_W-1:0] set_ca [SET_MAX];
      logic signed [COORD_W-1:0] set_co [SET_MAX];
      int n, src;
      bit noise;
      n     = ($urandom_range(0, 15) == 0) ? MAX_POINTS + $urandom_range(0, 3)
                                           : $urandom_range(1, 10);
      noise = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < n; k++) begin
         if (!noise && k > 0 && $urandom_range(0, 1)) begin
            src       = $urandom_range(0, k - 1);
            set_ca[k] = -set_ca[src] + jitter();
            set_co[k] = set_co[src] + jitter();
         end else begin
            set_ca[k] = pick_coord();
            set_co[k] = pick_coord();
         end
         if (cfg_axis)
            push_point(set_co[k], set_ca[k], k == n - 1, 1'b1);
         else
            push_point(set_ca[k], set_co[k], k == n - 1, 1'b1);
      end
   endtask

   // result sink: random stall bursts, check each transaction in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pair_reports_due.size() == 0) begin
               $error("result with none expected: orig_index %0d status %0d",
                      rsp_chan.orig_index, rsp_chan.pair_status);
               n_fail++;
            end else begin
               due = pair_reports_due.pop_front();
               n_checked++;
               if (rsp_chan.orig_index !== due.orig_index) begin
                  $error("orig_index: expected %0d, got %0d",
                         due.orig_index, rsp_chan.orig_index);
                  n_fail++;
               end
               if (rsp_chan.partner_index !== due.partner_index) begin
                  $error("partner_index: expected %0d, got %0d",
                         due.partner_index, rsp_chan.partner_index);
                  n_fail++;
               end
               if (rsp_chan.pair_status !== due.pair_status) begin
                  $error("pair_status: expected %0d, got %0d",
                         due.pair_status, rsp_chan.pair_status);
                  n_fail++;
               end
               if (rsp_chan.run_end !== due.run_end) begin
                  $error("run_end: expected %0d, got %0d", due.run_end, rsp_chan.run_end);
                  n_fail++;
               end
               if (rsp_chan.count_error !== due.count_error) begin
                  $error("count_error: expected %0d, got %0d",
                         due.count_error, rsp_chan.count_error);
                  n_fail++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left      <= hold_left - 1;
         end else if (idle_en && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left      <= $urandom_range(0, 13);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, pair_reports_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic             ph_axis;
      logic [TOL_W-1:0] ph_tol;
      logic [TOL_W-1:0] ph_eps;
      int               start_points;
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.x_coord    = '0;
      req_chan.y_coord    = '0;
      req_chan.last_point = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = REG_AXIS;
      csr_chan.data       = '0;
      cfg_axis            = 1'b0;
      cfg_tol             = 31'd1;
      cfg_eps             = 31'd1;
      pt_count            = 0;
      idle_en             = 1'b1;
      n_points            = 0;
      n_sets              = 0;
      n_settings          = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // hand-checked table under the reset settings
      foreach (steer_table[r]) begin
         push_point(steer_table[r].x, steer_table[r].y, steer_table[r].lst,
                    steer_table[r].n_typed == 0);
         if (steer_table[r].n_typed >= 1) pair_reports_due.push_back(steer_table[r].t0);
         if (steer_table[r].n_typed == 2) pair_reports_due.push_back(steer_table[r].t1);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin ph_axis = 1'b0; ph_tol = 31'h100;        ph_eps = 31'h100;        end
            1: begin ph_axis = 1'b1; ph_tol = 31'h0;          ph_eps = 31'h0;          end
            2: begin ph_axis = 1'b1; ph_tol = 31'h7FFF_FFFF;  ph_eps = 31'h7FFF_FFFF;  end
            3: begin
               ph_axis = 1'b0;
               ph_tol  = TOL_W'($urandom_range(1, 32'h0003_FFFF));
               ph_eps  = TOL_W'($urandom);
            end
            4: begin ph_axis = 1'b1; ph_tol = 31'h0001_0000;  ph_eps = 31'h0;          end
            default: begin ph_axis = 1'b0; ph_tol = 31'h1;    ph_eps = 31'h1;          end
         endcase
         wait_idle();
         write_settings(ph_axis, ph_tol, ph_eps);
         // no idling on either side in the closing phase
         idle_en      = (p < NUM_PHASES - 1);
         start_points = n_points;
         while (n_points - start_points < PHASE_POINTS) send_point_set();
      end

      wait_idle();
      $display("Covered %0d points in %0d sets under %0d register settings;",
               n_points, n_sets, n_settings + 1);
      $display("%0d pair reports compared.", n_checked);
      if (n_fail == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
